[rtl/sgdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sgdm_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 32;
    localparam int PASID_W    = 20;
    localparam int NODE_W     = 5;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // A run never emits more than this many descriptors.
    localparam int MAX_RES = 32;
    localparam int N_W     = $clog2(MAX_RES + 1);

    // Parameter defaults.
    localparam int SEG_DEPTH_DEF   = 16;
    localparam int ALIGN_BYTES_DEF = 128;

    // Command queue between the front and the back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_DST = 2'd1;
    localparam logic [OP_W-1:0] OP_START    = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FIRST_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FIRST_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LAST_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_LAST_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TO_DEVICE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PASSID       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_PASSID       = 3'd6;

    typedef enum logic [1:0] {
        K_LOAD_SRC,
        K_LOAD_DST,
        K_START
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
    } t_seg;

    typedef struct packed {
        logic [SIZE_W-1:0]  src_first_offset;
        logic [SIZE_W-1:0]  dst_first_offset;
        logic [SIZE_W-1:0]  src_last_len;
        logic [SIZE_W-1:0]  dst_last_len;
        logic               to_device;
        logic [PASID_W-1:0] src_passid;
        logic [PASID_W-1:0] dst_passid;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/sgdm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sgdm_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [sgdm_pkg::OP_W-1:0]       i_op,
    input  wire  [sgdm_pkg::ADDR_W-1:0]     i_seg_addr,
    input  wire  [sgdm_pkg::SIZE_W-1:0]     i_seg_size,
    output logic                            o_cmd_valid,
    input  wire                             i_cmd_ready,
    output sgdm_pkg::t_cmd                  o_cmd
);
    import sgdm_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    t_cmd               n_cmd;
    logic               known;
    logic               push;
    logic               pop;

    // Decode the operation; the reserved code is taken and dropped.
    always_comb begin
        n_cmd.addr = i_seg_addr;
        n_cmd.size = i_seg_size;
        n_cmd.kind = K_START;
        known      = 1'b1;
        unique case (i_op)
            OP_LOAD_SRC: n_cmd.kind = K_LOAD_SRC;
            OP_LOAD_DST: n_cmd.kind = K_LOAD_DST;
            OP_START:    n_cmd.kind = K_START;
            OP_RSVD:     known      = 1'b0;
            default:     known      = 1'b0;
        endcase
    end

    assign o_stall     = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_valid && !o_stall && known;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/sgdm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sgdm_back #(
    parameter int SEG_DEPTH   = sgdm_pkg::SEG_DEPTH_DEF,
    parameter int ALIGN_BYTES = sgdm_pkg::ALIGN_BYTES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cmd_valid,
    output logic                            o_cmd_ready,
    input  sgdm_pkg::t_cmd                  i_cmd,
    input  sgdm_pkg::t_cfg                  i_cfg,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [sgdm_pkg::ADDR_W-1:0]     o_read_addr,
    output logic [sgdm_pkg::ADDR_W-1:0]     o_write_addr,
    output logic [sgdm_pkg::SIZE_W-1:0]     o_length,
    output logic                            o_dir_to_device,
    output logic [sgdm_pkg::PASID_W-1:0]    o_passid,
    output logic                            o_unaligned,
    output logic [sgdm_pkg::NODE_W-1:0]     o_node_index,
    output logic                            o_empty_res,
    output logic                            o_last
);
    import sgdm_pkg::*;

    localparam int IDX_W = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int CNT_W = $clog2(SEG_DEPTH + 1);
    localparam int DBL_W = CNT_W + 1;
    localparam int CMP_W = (DBL_W > N_W) ? DBL_W : N_W;
    // ALIGN_BYTES is a power of two, so the remainder is a mask.
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(ALIGN_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_EMIT,
        S_EMPTY
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_src_cnt;
    logic [CNT_W-1:0]    r_dst_cnt;
    logic [CNT_W-1:0]    r_si;
    logic [CNT_W-1:0]    r_di;
    logic [SIZE_W-1:0]   r_soff;
    logic [SIZE_W-1:0]   r_doff;
    logic [N_W-1:0]      r_n;
    logic [N_W-1:0]      r_max;
    logic [SIZE_W-1:0]   r_src_last_tot;
    logic [SIZE_W-1:0]   r_dst_last_tot;
    logic                r_dir;
    logic [PASID_W-1:0]  r_pid;
    logic [SIZE_W-1:0]   r_ssz;
    logic [SIZE_W-1:0]   r_dsz;
    logic [ADDR_W-1:0]   r_sa;
    logic [ADDR_W-1:0]   r_da;
    logic                r_out_valid;

    t_seg                r_src_mem [SEG_DEPTH];
    t_seg                r_dst_mem [SEG_DEPTH];
    t_seg                r_src_rd;
    t_seg                r_dst_rd;

    logic                src_has_room;
    logic                dst_has_room;
    logic                wr_src;
    logic                wr_dst;
    logic                out_free;
    logic [CNT_W-1:0]    cnt_max;
    logic [CMP_W-1:0]    dbl_ext;
    logic [N_W-1:0]      n_max;
    logic                s_is_last;
    logic                d_is_last;
    logic [SIZE_W-1:0]   n_ssz;
    logic [SIZE_W-1:0]   n_dsz;
    logic [ADDR_W-1:0]   n_sa;
    logic [ADDR_W-1:0]   n_da;
    logic                s_adv;
    logic                d_adv;
    logic [SIZE_W-1:0]   cur;
    logic [CNT_W-1:0]    n_si;
    logic [CNT_W-1:0]    n_di;
    logic [N_W-1:0]      n_n;
    logic                cont;
    logic                n_unaligned;

    assign o_cmd_ready  = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign out_free     = !r_out_valid || !i_stall;

    assign src_has_room = (r_src_cnt < CNT_W'(SEG_DEPTH));
    assign dst_has_room = (r_dst_cnt < CNT_W'(SEG_DEPTH));
    assign wr_src = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == K_LOAD_SRC)
                    && src_has_room;
    assign wr_dst = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == K_LOAD_DST)
                    && dst_has_room;

    // Descriptor budget: twice the longer list, capped at MAX_RES.
    assign cnt_max = (r_src_cnt > r_dst_cnt) ? r_src_cnt : r_dst_cnt;
    assign dbl_ext = CMP_W'({cnt_max, 1'b0});
    assign n_max   = (dbl_ext > CMP_W'(MAX_RES)) ? N_W'(MAX_RES) : N_W'(dbl_ext);

    // Bytes left in the current segments and the descriptor addresses.
    assign s_is_last = ((r_si + CNT_W'(1)) == r_src_cnt);
    assign d_is_last = ((r_di + CNT_W'(1)) == r_dst_cnt);
    assign n_ssz = (s_is_last ? r_src_last_tot : r_src_rd.size) - r_soff;
    assign n_dsz = (d_is_last ? r_dst_last_tot : r_dst_rd.size) - r_doff;
    assign n_sa  = r_src_rd.addr + ADDR_W'(r_soff);
    assign n_da  = r_dst_rd.addr + ADDR_W'(r_doff);

    // A side whose remaining size is not larger moves on; on a tie both move.
    assign s_adv = (r_ssz <= r_dsz);
    assign d_adv = (r_dsz <= r_ssz);
    assign cur   = s_adv ? r_ssz : r_dsz;
    assign n_si  = r_si + CNT_W'(s_adv);
    assign n_di  = r_di + CNT_W'(d_adv);
    assign n_n   = r_n + N_W'(1);
    assign cont  = (n_n < r_max) && (n_si < r_src_cnt) && (n_di < r_dst_cnt);
    assign n_unaligned = ((r_sa & ALIGN_MASK) != '0) || ((r_da & ALIGN_MASK) != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_src_cnt   <= '0;
            r_dst_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output steps load a new transfer themselves when the old one leaves.
            if (r_out_valid && !i_stall && r_state != S_EMIT && r_state != S_EMPTY) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            K_LOAD_SRC: begin
                                if (src_has_room) begin
                                    r_src_cnt <= r_src_cnt + CNT_W'(1);
                                end
                            end
                            K_LOAD_DST: begin
                                if (dst_has_room) begin
                                    r_dst_cnt <= r_dst_cnt + CNT_W'(1);
                                end
                            end
                            K_START: begin
                                if (r_src_cnt == '0 || r_dst_cnt == '0) begin
                                    r_state <= S_EMPTY;
                                end else begin
                                    r_si   <= '0;
                                    r_di   <= '0;
                                    r_soff <= i_cfg.src_first_offset;
                                    r_doff <= i_cfg.dst_first_offset;
                                    r_n    <= '0;
                                    r_max  <= n_max;
                                    r_dir  <= i_cfg.to_device;
                                    r_pid  <= i_cfg.to_device ? i_cfg.dst_passid
                                                              : i_cfg.src_passid;
                                    // A one-segment list counts its length from the offset.
                                    r_src_last_tot <= i_cfg.src_last_len +
                                        ((r_src_cnt == CNT_W'(1)) ? i_cfg.src_first_offset
                                                                  : '0);
                                    r_dst_last_tot <= i_cfg.dst_last_len +
                                        ((r_dst_cnt == CNT_W'(1)) ? i_cfg.dst_first_offset
                                                                  : '0);
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_ssz   <= n_ssz;
                    r_dsz   <= n_dsz;
                    r_sa    <= n_sa;
                    r_da    <= n_da;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        o_read_addr     <= r_sa;
                        o_write_addr    <= r_da;
                        o_length        <= cur;
                        o_dir_to_device <= r_dir;
                        o_passid        <= r_pid;
                        o_unaligned     <= n_unaligned;
                        o_node_index    <= r_n[NODE_W-1:0];
                        o_empty_res     <= 1'b0;
                        o_last          <= !cont;
                        r_si            <= n_si;
                        r_di            <= n_di;
                        r_soff          <= s_adv ? '0 : r_soff + cur;
                        r_doff          <= d_adv ? '0 : r_doff + cur;
                        r_n             <= n_n;
                        if (cont) begin
                            r_state <= S_READ;
                        end else begin
                            r_src_cnt <= '0;
                            r_dst_cnt <= '0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        o_read_addr     <= '0;
                        o_write_addr    <= '0;
                        o_length        <= '0;
                        o_dir_to_device <= 1'b0;
                        o_passid        <= '0;
                        o_unaligned     <= 1'b0;
                        o_node_index    <= '0;
                        o_empty_res     <= 1'b1;
                        o_last          <= 1'b1;
                        r_src_cnt       <= '0;
                        r_dst_cnt       <= '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Segment stores: written at the fill count, read at the walk indexes.
    always_ff @(posedge i_clk) begin
        if (wr_src) begin
            r_src_mem[r_src_cnt[IDX_W-1:0]] <= {i_cmd.addr, i_cmd.size};
        end
        if (wr_dst) begin
            r_dst_mem[r_dst_cnt[IDX_W-1:0]] <= {i_cmd.addr, i_cmd.size};
        end
        if (r_state == S_READ) begin
            r_src_rd <= r_src_mem[r_si[IDX_W-1:0]];
            r_dst_rd <= r_dst_mem[r_di[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

[rtl/sg_list_dma_descriptor_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Scatter-gather descriptor merge.
// Input channel (i_valid / o_stall): each transfer is one item. Op load-source
// and load-destination append a segment (address, size) to their list; a
// full list ignores the load. Op start walks both lists and emits DMA
// descriptors; the reserved op is taken and dropped.
// Output channel (o_valid / i_stall): one descriptor per transfer, o_last on
// the final one of a run. A run with an empty list gives one transfer with
// o_empty_res and o_last set. Both lists are cleared at the end of every run.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx; write
// only while the block is idle.
// Flow: items pass a two-entry command queue, then the back end, which takes
// a new item only while it is idle. Loads stream at one per cycle while no
// walk is under way. A walk passes these steps for each descriptor: memory
// read, size and address calculation, output register. The first descriptor
// is valid once the start has passed the queue and these steps. An empty run
// gives its result from its own step straight into the output register.
// Reset clears the lists, the queue, the output valid and the configuration registers.
// When the receiver stalls, the output register holds; the walk waits at
// its output step and the queue then fills and raises o_stall.
module sg_list_dma_descriptor_merge #(
    parameter int SEG_DEPTH   = sgdm_pkg::SEG_DEPTH_DEF,
    parameter int ALIGN_BYTES = sgdm_pkg::ALIGN_BYTES_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [sgdm_pkg::OP_W-1:0]           i_op,
    input  wire  [sgdm_pkg::ADDR_W-1:0]         i_seg_addr,
    input  wire  [sgdm_pkg::SIZE_W-1:0]         i_seg_size,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [sgdm_pkg::ADDR_W-1:0]         o_read_addr,
    output logic [sgdm_pkg::ADDR_W-1:0]         o_write_addr,
    output logic [sgdm_pkg::SIZE_W-1:0]         o_length,
    output logic                                o_dir_to_device,
    output logic [sgdm_pkg::PASID_W-1:0]        o_passid,
    output logic                                o_unaligned,
    output logic [sgdm_pkg::NODE_W-1:0]         o_node_index,
    output logic                                o_empty_res,
    output logic                                o_last,
    input  wire                                 i_cfg_we,
    input  wire  [sgdm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sgdm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sgdm_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    logic  cmd_valid;
    logic  cmd_ready;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_FIRST_OFFSET: r_cfg.src_first_offset <= i_cfg_data;
                REG_DST_FIRST_OFFSET: r_cfg.dst_first_offset <= i_cfg_data;
                REG_SRC_LAST_LEN:     r_cfg.src_last_len     <= i_cfg_data;
                REG_DST_LAST_LEN:     r_cfg.dst_last_len     <= i_cfg_data;
                REG_TO_DEVICE:        r_cfg.to_device        <= i_cfg_data[0];
                REG_SRC_PASSID:       r_cfg.src_passid       <= i_cfg_data[PASID_W-1:0];
                REG_DST_PASSID:       r_cfg.dst_passid       <= i_cfg_data[PASID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: decodes each item and queues the known ones for the walker.
    sgdm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_seg_addr  (i_seg_addr),
        .i_seg_size  (i_seg_size),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Back end: segment stores, list walk and the output register.
    sgdm_back #(
        .SEG_DEPTH   (SEG_DEPTH),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .i_cfg           (r_cfg),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_addr     (o_read_addr),
        .o_write_addr    (o_write_addr),
        .o_length        (o_length),
        .o_dir_to_device (o_dir_to_device),
        .o_passid        (o_passid),
        .o_unaligned     (o_unaligned),
        .o_node_index    (o_node_index),
        .o_empty_res     (o_empty_res),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

[bench/sgdm_descriptor_check.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port of the descriptor merge block,
// keeps its own copy of the segment lists and registers, and compares every
// descriptor that leaves the block with the one it predicted.
module sgdm_descriptor_check #(
    parameter int SEG_DEPTH   = sgdm_pkg::SEG_DEPTH_DEF,
    parameter int ALIGN_BYTES = sgdm_pkg::ALIGN_BYTES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  wire  [sgdm_pkg::OP_W-1:0]       i_op,
    input  wire  [sgdm_pkg::ADDR_W-1:0]     i_seg_addr,
    input  wire  [sgdm_pkg::SIZE_W-1:0]     i_seg_size,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  wire  [sgdm_pkg::ADDR_W-1:0]     i_read_addr,
    input  wire  [sgdm_pkg::ADDR_W-1:0]     i_write_addr,
    input  wire  [sgdm_pkg::SIZE_W-1:0]     i_length,
    input  wire                             i_dir_to_device,
    input  wire  [sgdm_pkg::PASID_W-1:0]    i_passid,
    input  wire                             i_unaligned,
    input  wire  [sgdm_pkg::NODE_W-1:0]     i_node_index,
    input  wire                             i_empty_res,
    input  wire                             i_last,
    input  wire                             i_cfg_we,
    input  wire  [sgdm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [sgdm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    import sgdm_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  read_addr;
        logic [ADDR_W-1:0]  write_addr;
        logic [SIZE_W-1:0]  length;
        logic               dir_to_device;
        logic [PASID_W-1:0] passid;
        logic               unaligned;
        logic [NODE_W-1:0]  node_index;
        logic               empty_res;
        logic               last;
    } t_descr;

    t_cfg              regs;
    logic [ADDR_W-1:0] src_base_mem [SEG_DEPTH];
    logic [SIZE_W-1:0] src_size_mem [SEG_DEPTH];
    logic [ADDR_W-1:0] dst_base_mem [SEG_DEPTH];
    logic [SIZE_W-1:0] dst_size_mem [SEG_DEPTH];
    int unsigned       src_cnt;
    int unsigned       dst_cnt;
    t_descr            descriptors_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Bytes still to move in segment idx of a list, given the offset already used.
    function automatic logic [SIZE_W-1:0] bytes_left(
        int unsigned idx, int unsigned cnt, logic [SIZE_W-1:0] seg_size,
        logic [SIZE_W-1:0] first_off, logic [SIZE_W-1:0] last_len,
        logic [SIZE_W-1:0] off);
        logic [SIZE_W-1:0] base;
        base = (cnt == 1) ? first_off : '0;
        if (idx + 1 < cnt)
            return seg_size - off;
        return last_len + base - off;
    endfunction

    // Walks both lists in step and queues the descriptors that a start yields.
    task automatic walk_lists();
        t_descr            d;
        t_descr            prev;
        int unsigned       limit;
        int unsigned       n;
        int unsigned       si;
        int unsigned       di;
        logic [SIZE_W-1:0] soff;
        logic [SIZE_W-1:0] doff;
        logic [SIZE_W-1:0] ssz;
        logic [SIZE_W-1:0] dsz;
        logic [SIZE_W-1:0] cur;
        if (src_cnt == 0 || dst_cnt == 0) begin
            d = '0;
            d.empty_res = 1'b1;
            d.last = 1'b1;
            descriptors_due.push_back(d);
        end else begin
            limit = 2 * ((src_cnt > dst_cnt) ? src_cnt : dst_cnt);
            if (limit > MAX_RES)
                limit = MAX_RES;
            si = 0;
            di = 0;
            n = 0;
            soff = regs.src_first_offset;
            doff = regs.dst_first_offset;
            prev = '0;
            while (n < limit && si < src_cnt && di < dst_cnt) begin
                ssz = bytes_left(si, src_cnt, src_size_mem[si], regs.src_first_offset,
                                 regs.src_last_len, soff);
                dsz = bytes_left(di, dst_cnt, dst_size_mem[di], regs.dst_first_offset,
                                 regs.dst_last_len, doff);
                cur = (ssz < dsz) ? ssz : dsz;
                d = '0;
                d.read_addr = src_base_mem[si] + {32'b0, soff};
                d.write_addr = dst_base_mem[di] + {32'b0, doff};
                d.length = cur;
                d.dir_to_device = regs.to_device;
                d.passid = regs.to_device ? regs.dst_passid : regs.src_passid;
                d.unaligned = ((d.read_addr % 64'(ALIGN_BYTES)) != 0) ||
                              ((d.write_addr % 64'(ALIGN_BYTES)) != 0);
                d.node_index = NODE_W'(n);
                // The previous one is not the last of the run, so it can go now.
                if (n != 0)
                    descriptors_due.push_back(prev);
                prev = d;
                soff = soff + cur;
                doff = doff + cur;
                if (cur == ssz) begin
                    si++;
                    soff = '0;
                end
                if (cur == dsz) begin
                    di++;
                    doff = '0;
                end
                n++;
            end
            prev.last = 1'b1;
            descriptors_due.push_back(prev);
        end
        src_cnt = 0;
        dst_cnt = 0;
    endtask

    task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_descr want;
        if (!i_rst_n) begin
            regs = '0;
            src_cnt = 0;
            dst_cnt = 0;
            descriptors_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SRC_FIRST_OFFSET: regs.src_first_offset = i_cfg_data;
                    REG_DST_FIRST_OFFSET: regs.dst_first_offset = i_cfg_data;
                    REG_SRC_LAST_LEN:     regs.src_last_len = i_cfg_data;
                    REG_DST_LAST_LEN:     regs.dst_last_len = i_cfg_data;
                    REG_TO_DEVICE:        regs.to_device = i_cfg_data[0];
                    REG_SRC_PASSID:       regs.src_passid = i_cfg_data[PASID_W-1:0];
                    REG_DST_PASSID:       regs.dst_passid = i_cfg_data[PASID_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (descriptors_due.size() == 0) begin
                    $error("descriptor with none due: read_addr %h write_addr %h length %h",
                           i_read_addr, i_write_addr, i_length);
                    o_fail_count++;
                end else begin
                    want = descriptors_due.pop_front();
                    check_field("read_addr", want.read_addr, i_read_addr);
                    check_field("write_addr", want.write_addr, i_write_addr);
                    check_field("length", 64'(want.length), 64'(i_length));
                    check_field("dir_to_device", 64'(want.dir_to_device), 64'(i_dir_to_device));
                    check_field("passid", 64'(want.passid), 64'(i_passid));
                    check_field("unaligned", 64'(want.unaligned), 64'(i_unaligned));
                    check_field("node_index", 64'(want.node_index), 64'(i_node_index));
                    check_field("empty_res", 64'(want.empty_res), 64'(i_empty_res));
                    check_field("last", 64'(want.last), 64'(i_last));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_LOAD_SRC: begin
                        if (src_cnt < SEG_DEPTH) begin
                            src_base_mem[src_cnt] = i_seg_addr;
                            src_size_mem[src_cnt] = i_seg_size;
                            src_cnt++;
                        end
                    end
                    OP_LOAD_DST: begin
                        if (dst_cnt < SEG_DEPTH) begin
                            dst_base_mem[dst_cnt] = i_seg_addr;
                            dst_size_mem[dst_cnt] = i_seg_size;
                            dst_cnt++;
                        end
                    end
                    OP_START: walk_lists();
                    default: ;
                endcase
            end
        end
        o_pending = descriptors_due.size();
    end

endmodule

[bench/sg_list_dma_descriptor_merge_tb.sv]
`timescale 1ns / 1ps

// Top of the descriptor merge bench. This module only makes stimulus and
// gives the verdict; sgdm_descriptor_check predicts and compares every
// descriptor transfer and reports how many checks failed.
module sg_list_dma_descriptor_merge_tb;

    import sgdm_pkg::*;

    localparam int          SEG_DEPTH     = SEG_DEPTH_DEF;
    localparam int          ITEM_TARGET   = 170;
    localparam int          ITEMS_PER_CFG = 35;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // Patterns the receiver cycles through while it is not in the long hold-off.
    typedef enum int {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_TOGGLE,
        FLOW_HEAVY
    } t_flow;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  dut_stall;
    logic [OP_W-1:0]       in_op;
    logic [ADDR_W-1:0]     in_seg_addr;
    logic [SIZE_W-1:0]     in_seg_size;
    logic                  out_valid;
    logic                  out_stall;
    logic [ADDR_W-1:0]     desc_read_addr;
    logic [ADDR_W-1:0]     desc_write_addr;
    logic [SIZE_W-1:0]     desc_length;
    logic                  desc_dir_to_device;
    logic [PASID_W-1:0]    desc_passid;
    logic                  desc_unaligned;
    logic [NODE_W-1:0]     desc_node_index;
    logic                  desc_empty_res;
    logic                  desc_last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    descriptors_pending;
    int unsigned           cycles;
    int unsigned           burst_left;
    int unsigned           sent_items;
    bit                    hold_req;

    sg_list_dma_descriptor_merge i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (dut_stall),
        .i_op            (in_op),
        .i_seg_addr      (in_seg_addr),
        .i_seg_size      (in_seg_size),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_read_addr     (desc_read_addr),
        .o_write_addr    (desc_write_addr),
        .o_length        (desc_length),
        .o_dir_to_device (desc_dir_to_device),
        .o_passid        (desc_passid),
        .o_unaligned     (desc_unaligned),
        .o_node_index    (desc_node_index),
        .o_empty_res     (desc_empty_res),
        .o_last          (desc_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    sgdm_descriptor_check i_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (dut_stall),
        .i_op            (in_op),
        .i_seg_addr      (in_seg_addr),
        .i_seg_size      (in_seg_size),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_read_addr     (desc_read_addr),
        .i_write_addr    (desc_write_addr),
        .i_length        (desc_length),
        .i_dir_to_device (desc_dir_to_device),
        .i_passid        (desc_passid),
        .i_unaligned     (desc_unaligned),
        .i_node_index    (desc_node_index),
        .i_empty_res     (desc_empty_res),
        .i_last          (desc_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (descriptors_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog. The slowest correct run is far below this: a few dozen starts
    // of at most 32 descriptors each, stretched by receiver stalls, plus sender
    // gaps and the long hold-off.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver. It switches between patterns on stretches of random length,
    // so that stalls land on every step of a walk, and some stretches never
    // stall. Once the stimulus asks for it, it holds off for a long stretch so
    // that the walk backs up into the command queue and the input stalls.
    initial begin
        int unsigned stretch;
        int unsigned held;
        t_flow       flow;
        out_stall = 1'b0;
        stretch = 0;
        held = 0;
        flow = FLOW_FREE;
        forever begin
            @(negedge clk);
            if (hold_req && held < HOLD_CYCLES) begin
                held++;
                out_stall <= 1'b1;
            end else begin
                if (stretch == 0) begin
                    flow = t_flow'($urandom_range(0, 3));
                    stretch = $urandom_range(4, 60);
                end
                stretch--;
                case (flow)
                    FLOW_FREE:   out_stall <= 1'b0;
                    FLOW_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
                    FLOW_TOGGLE: out_stall <= ~out_stall;
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Offers one item and returns at the falling edge after its transfer. The
    // sender works in bursts; between bursts valid drops for a random gap.
    task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                             logic [SIZE_W-1:0] size);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        in_valid    <= 1'b1;
        in_op       <= op;
        in_seg_addr <= addr;
        in_seg_size <= size;
        @(posedge clk);
        while (dut_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent_items++;
    endtask

    // Lowers valid and waits until every predicted descriptor has come out,
    // then lets the last loads drain from the queue before registers change.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (descriptors_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic write_config(t_cfg c);
        write_reg(REG_SRC_FIRST_OFFSET, c.src_first_offset);
        write_reg(REG_DST_FIRST_OFFSET, c.dst_first_offset);
        write_reg(REG_SRC_LAST_LEN, c.src_last_len);
        write_reg(REG_DST_LAST_LEN, c.dst_last_len);
        write_reg(REG_TO_DEVICE, CFG_DATA_W'(c.to_device));
        write_reg(REG_SRC_PASSID, CFG_DATA_W'(c.src_passid));
        write_reg(REG_DST_PASSID, CFG_DATA_W'(c.dst_passid));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0, 1:    return '0;
            2:       return $urandom_range(0, 300);
            3:       return '1;
            4:       return $urandom;
            default: return $urandom_range(1, 16) * 128;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_last_len();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    function automatic t_cfg pick_config();
        t_cfg c;
        c.src_first_offset = pick_offset();
        c.dst_first_offset = pick_offset();
        c.src_last_len     = pick_last_len();
        c.dst_last_len     = pick_last_len();
        c.to_device        = 1'($urandom_range(0, 1));
        c.src_passid       = $urandom_range(0, 4) == 0 ? '1 : PASID_W'($urandom);
        c.dst_passid       = $urandom_range(0, 4) == 0 ? '1 : PASID_W'($urandom);
        return c;
    endfunction

    // Segments lean toward small, 128-byte multiples so that walks step
    // through many descriptors, with zero, full-range and odd values mixed in.
    task automatic make_segment(output logic [ADDR_W-1:0] addr, output logic [SIZE_W-1:0] size);
        case ($urandom_range(0, 4))
            0:       addr = {$urandom, $urandom} & ~64'h7F;
            1:       addr = {$urandom, $urandom};
            2:       addr = '1;
            3:       addr = '0;
            default: addr = 64'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       size = '0;
            1:       size = '1;
            2:       size = $urandom;
            3, 4:    size = $urandom_range(1, 16) * 128;
            default: size = $urandom_range(1, 1000);
        endcase
    endtask

    function automatic int unsigned pick_list_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 4);
    endfunction

    // Loads both lists in a random interleave, with an occasional reserved
    // item thrown in, then starts the walk.
    task automatic run_lists(int unsigned n_src, int unsigned n_dst);
        int unsigned       s_left;
        int unsigned       d_left;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        s_left = n_src;
        d_left = n_dst;
        while (s_left + d_left > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_RSVD, {$urandom, $urandom}, $urandom);
            make_segment(addr, size);
            if (d_left == 0 || (s_left != 0 && $urandom_range(0, 1) == 0)) begin
                send_item(OP_LOAD_SRC, addr, size);
                s_left--;
            end else begin
                send_item(OP_LOAD_DST, addr, size);
                d_left--;
            end
        end
        send_item(OP_START, {$urandom, $urandom}, $urandom);
    endtask

    initial begin
        t_cfg        c;
        int unsigned next_cfg_at;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_op       = OP_LOAD_SRC;
        in_seg_addr = '0;
        in_seg_size = '0;
        cfg_we      = 1'b0;
        cfg_idx     = REG_SRC_FIRST_OFFSET;
        cfg_data    = '0;
        burst_left  = 0;
        sent_items  = 0;
        hold_req    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With both lists empty a start yields the single empty
        // result; a reserved item yields nothing; a start with only a source
        // list is still empty and must clear the source count.
        send_item(OP_START, '1, '1);
        send_item(OP_RSVD, '1, '1);
        send_item(OP_LOAD_SRC, '1, '1);
        send_item(OP_START, '0, '0);
        wait_idle();

        // Aligned lists with a zero-length middle segment and last segments
        // whose loaded size must be ignored in favor of the registers.
        c.src_first_offset = '0;
        c.dst_first_offset = '0;
        c.src_last_len     = 32'd256;
        c.dst_last_len     = 32'd384;
        c.to_device        = 1'b1;
        c.src_passid       = '1;
        c.dst_passid       = 20'h5A5A5;
        write_config(c);
        send_item(OP_LOAD_SRC, 64'h0, 32'd128);
        send_item(OP_LOAD_DST, 64'h1000, 32'd200);
        send_item(OP_LOAD_SRC, 64'hFFFF_FFFF_FFFF_FF80, 32'd0);
        send_item(OP_LOAD_DST, 64'h2000, '1);
        send_item(OP_LOAD_SRC, 64'h3000_0000_0000_0000, 32'h1234);
        send_item(OP_START, '0, '0);
        wait_idle();

        // Full-range offsets on single-segment lists: the source address sum wraps
        // past the top of the space and both sizes come out as zero.
        c.src_first_offset = '1;
        c.dst_first_offset = '1;
        c.src_last_len     = '0;
        c.dst_last_len     = '0;
        c.to_device        = 1'b0;
        c.src_passid       = '0;
        c.dst_passid       = '1;
        write_config(c);
        send_item(OP_LOAD_SRC, '1, '1);
        send_item(OP_LOAD_DST, '0, '0);
        send_item(OP_START, '1, '0);
        wait_idle();

        // Small unaligned offsets and full-range last lengths, with a
        // reserved item in the middle of the loads.
        c.src_first_offset = 32'd5;
        c.dst_first_offset = 32'd130;
        c.src_last_len     = '1;
        c.dst_last_len     = '1;
        c.to_device        = 1'b1;
        c.src_passid       = 20'h0F0F0;
        c.dst_passid       = 20'hABCDE;
        write_config(c);
        send_item(OP_LOAD_SRC, 64'h0000_0000_0001_0000, 32'd1000);
        send_item(OP_LOAD_DST, 64'h5555_5555_5555_5500, 32'd300);
        send_item(OP_RSVD, 64'h0, 32'd0);
        send_item(OP_LOAD_SRC, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
        send_item(OP_LOAD_DST, 64'h80, 32'd64);
        send_item(OP_LOAD_DST, 64'h100, 32'd7);
        send_item(OP_START, '0, '1);

        // Random part. Most traffic is loaded lists followed by a start; some
        // starts find an empty list, and reserved items appear as noise.
        // Registers change every few dozen items, always with the block idle.
        next_cfg_at = 0;
        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= next_cfg_at) begin
                wait_idle();
                write_config(pick_config());
                next_cfg_at = sent_items + ITEMS_PER_CFG;
            end
            if (!hold_req && sent_items >= ITEM_TARGET / 2) begin
                // The receiver holds off while a short walk is blocked; the
                // loads behind it fill the queue, then both lists overflow.
                hold_req = 1'b1;
                run_lists(2, 2);
                run_lists(SEG_DEPTH + 1, SEG_DEPTH + 1);
            end else begin
                case ($urandom_range(0, 15))
                    0:       send_item(OP_RSVD, {$urandom, $urandom}, $urandom);
                    1:       run_lists($urandom_range(0, 2), 0);
                    2:       run_lists(0, $urandom_range(0, 2));
                    default: run_lists(pick_list_len(), pick_list_len());
                endcase
            end
        end

        in_valid <= 1'b0;
        while (descriptors_pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
